@@ sv/whb_pkg.sv @@
// Shared constants, request codes and controller/datapath handshake types.
`default_nettype none
package whb_pkg;
  localparam int NBINS    = 256;
  localparam int NSLOTS   = NBINS + 2;
  localparam int IDX_W    = 9;
  localparam int CNT_W    = 6;
  localparam int DIV_BITS = 32;

  localparam logic [IDX_W-1:0] IDX_UNDER = '0;
  localparam logic [IDX_W-1:0] IDX_OVER  = IDX_W'(NBINS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NSLOTS - 1);
  localparam logic [8:0]       BINS_MAX  = 9'(NBINS);

  typedef enum logic [1:0] {
    REQ_FILL  = 2'd0,
    REQ_COUNT = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  localparam logic [2:0] CFG_LOWER = 3'd0;
  localparam logic [2:0] CFG_UPPER = 3'd1;
  localparam logic [2:0] CFG_WIDTH = 3'd2;
  localparam logic [2:0] CFG_BINS  = 3'd3;
  localparam logic [2:0] CFG_DEPTH = 3'd4;

  typedef enum logic [1:0] {
    ROUTE_NONE  = 2'd0,
    ROUTE_MEM   = 2'd1,
    ROUTE_DIV   = 2'd2,
    ROUTE_CLEAR = 2'd3
  } route_t;

  typedef struct packed {
    logic accept;
    logic decide;
    logic div_start;
    logic take_q;
    logic rd;
    logic upd;
    logic clr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    route_t route;
    logic   div_done;
    logic   q_ok;
    logic   clr_last;
    logic   out_busy;
  } stat_t;
endpackage
`default_nettype wire

@@ sv/weighted_histogram_accumulator_unit.sv @@
// Top level of the weighted histogram accumulator.
// Uniform-bin Q16.16 histogram with an underflow bin 0 and an overflow bin 257, one
// request at a time, one result per request. After reset the bin memory is swept to
// zero with in_ready low. A weighted or count-only fill that lands between the bounds
// goes through the restoring divider that turns the offset into a bin number; fills
// outside the bounds and in-range reads go straight to the bin read and update, a
// zero-weight fill straight to the result; a clear sweeps the memory to zero. A new
// request is taken while an earlier result still waits on the output register.
`default_nettype none
module weighted_histogram_accumulator_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [31:0]               cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                req_type,
  input  wire logic signed [31:0]        coordinate,
  input  wire logic signed [31:0]        weight,
  input  wire logic [15:0]               count_add,
  input  wire logic [whb_pkg::IDX_W-1:0] bin_select,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [whb_pkg::IDX_W-1:0]      bin_index,
  output logic                           bin_placed,
  output logic signed [47:0]             bin_sum,
  output logic [63:0]                    bin_second,
  output logic [31:0]                    bin_hits,
  output logic [39:0]                    total_fills,
  output logic [31:0]                    nonzero_fills
);
  whb_pkg::cmd_t  cmd;
  whb_pkg::stat_t st;

  whb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  whb_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .coordinate    (coordinate),
    .weight        (weight),
    .count_add     (count_add),
    .bin_select    (bin_select),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .bin_index     (bin_index),
    .bin_placed    (bin_placed),
    .bin_sum       (bin_sum),
    .bin_second    (bin_second),
    .bin_hits      (bin_hits),
    .total_fills   (total_fills),
    .nonzero_fills (nonzero_fills)
  );
endmodule
`default_nettype wire

@@ sv/whb_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module whb_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [30:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [whb_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic [30:0]               rem;
  logic [30:0]               dsr;
  logic [31:0]               shifted;
  logic                      ge;

  assign shifted = {rem, quotient[31]};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= whb_pkg::CNT_W'(whb_pkg::DIV_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == whb_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= ge ? 31'(shifted - {1'b0, dsr}) : shifted[30:0];
      quotient <= {quotient[30:0], ge};
    end
  end
endmodule
`default_nettype wire

@@ sv/whb_ctrl.sv @@
// Request sequencer: decode, divide, read-modify-write, clear sweep, result hand-off.
`default_nettype none
module whb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire whb_pkg::stat_t st,
  output whb_pkg::cmd_t       cmd
);
  typedef enum logic [7:0] {
    S_INIT = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_DEC  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_UPD  = 8'b0010_0000,
    S_DONE = 8'b0100_0000,
    S_CLR  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_INIT: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        case (st.route)
          whb_pkg::ROUTE_MEM: state_next = S_RD;
          whb_pkg::ROUTE_DIV: begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
          whb_pkg::ROUTE_CLEAR: state_next = S_CLR;
          default: state_next = S_DONE;
        endcase
      end
      S_DIV: begin
        if (st.div_done) begin
          if (st.q_ok) begin
            cmd.take_q = 1'b1;
            state_next = S_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_next = S_DONE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end
endmodule
`default_nettype wire

@@ sv/whb_dp.sv @@
// Datapath: config registers, counters, bin memory, update arithmetic, result register.
`default_nettype none
module whb_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire whb_pkg::cmd_t               cmd,
  output whb_pkg::stat_t                   st,
  input  wire logic                        cfg_write,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [31:0]                 cfg_data,
  input  wire logic [1:0]                  req_type,
  input  wire logic signed [31:0]          coordinate,
  input  wire logic signed [31:0]          weight,
  input  wire logic [15:0]                 count_add,
  input  wire logic [whb_pkg::IDX_W-1:0]   bin_select,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [whb_pkg::IDX_W-1:0]        bin_index,
  output logic                             bin_placed,
  output logic signed [47:0]               bin_sum,
  output logic [63:0]                      bin_second,
  output logic [31:0]                      bin_hits,
  output logic [39:0]                      total_fills,
  output logic [31:0]                      nonzero_fills
);
  logic signed [31:0] lower_bound, upper_bound;
  logic [30:0]        bin_width;
  logic [8:0]         bins_in_use;
  logic [1:0]         track_depth;

  logic [39:0] fill_counter;
  logic [31:0] nonzero_counter;

  whb_pkg::req_t      req;
  logic signed [31:0] coord, wgt;
  logic [whb_pkg::IDX_W-1:0] sel, idx, clr_cnt;
  logic placed;

  logic [143:0] mem [whb_pkg::NSLOTS];
  logic [143:0] rdata, wdata;
  logic [63:0]  sq;

  logic [40:0] fill_add;
  logic [39:0] fill_inc;
  logic [32:0] off_ext;
  logic [31:0] quot;
  logic        div_done;
  logic [8:0]  n_bins;
  logic [whb_pkg::IDX_W-1:0] direct_idx;
  whb_pkg::route_t route;

  logic signed [47:0] old_sum, new_sum;
  logic [63:0] old_sec, new_sec;
  logic [31:0] old_hit, new_hit;
  logic signed [48:0] sum_ext, addend;
  logic [64:0] sec_add;
  logic [31:0] wabs;
  logic        is_fill, is_count, edge_bin, deep2, deep3;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= '0;
      upper_bound <= 32'sd16777216;
      bin_width   <= 31'd65536;
      bins_in_use <= 9'd256;
      track_depth <= 2'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        whb_pkg::CFG_LOWER: lower_bound <= cfg_data;
        whb_pkg::CFG_UPPER: upper_bound <= cfg_data;
        whb_pkg::CFG_WIDTH: bin_width   <= cfg_data[30:0];
        whb_pkg::CFG_BINS:  bins_in_use <= cfg_data[8:0];
        whb_pkg::CFG_DEPTH: track_depth <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // counters, updated as the request is taken
  assign fill_add = {1'b0, fill_counter} + 41'(count_add);
  assign fill_inc = (fill_counter == '1) ? fill_counter : fill_counter + 40'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_counter    <= '0;
      nonzero_counter <= '0;
    end else if (cmd.accept) begin
      case (whb_pkg::req_t'(req_type))
        whb_pkg::REQ_FILL: begin
          fill_counter <= fill_add[40] ? '1 : fill_add[39:0];
          if (weight != 0 && nonzero_counter != '1)
            nonzero_counter <= nonzero_counter + 32'd1;
        end
        whb_pkg::REQ_COUNT: fill_counter <= fill_inc;
        whb_pkg::REQ_CLEAR: begin
          fill_counter    <= '0;
          nonzero_counter <= '0;
        end
        default: ;
      endcase
    end
  end

  // request capture and routing
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req   <= whb_pkg::req_t'(req_type);
      coord <= coordinate;
      wgt   <= weight;
      sel   <= bin_select;
    end
  end

  always_comb begin
    route      = whb_pkg::ROUTE_NONE;
    direct_idx = whb_pkg::IDX_UNDER;
    case (req)
      whb_pkg::REQ_READ: begin
        direct_idx = sel;
        if (sel <= whb_pkg::IDX_OVER) route = whb_pkg::ROUTE_MEM;
      end
      whb_pkg::REQ_CLEAR: route = whb_pkg::ROUTE_CLEAR;
      default: begin
        if (req == whb_pkg::REQ_FILL && wgt == 0) begin
          route = whb_pkg::ROUTE_NONE;
        end else if (coord < lower_bound) begin
          route = whb_pkg::ROUTE_MEM;
        end else if (coord > upper_bound) begin
          route      = whb_pkg::ROUTE_MEM;
          direct_idx = whb_pkg::IDX_OVER;
        end else if (bin_width != '0) begin
          route = whb_pkg::ROUTE_DIV;
        end
      end
    endcase
  end

  assign off_ext = {coord[31], coord} - {lower_bound[31], lower_bound};
  assign n_bins  = (bins_in_use > whb_pkg::BINS_MAX) ? whb_pkg::BINS_MAX : bins_in_use;

  whb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (off_ext[31:0]),
    .divisor  (bin_width),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.decide)      idx <= direct_idx;
    else if (cmd.take_q) idx <= quot[whb_pkg::IDX_W-1:0] + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.accept) placed <= 1'b0;
    else if (cmd.rd)       placed <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.accept) clr_cnt <= '0;
    else if (cmd.clr)      clr_cnt <= clr_cnt + 1'b1;
  end

  // bin memory: one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.clr)      mem[clr_cnt] <= '0;
    else if (cmd.upd) mem[idx]     <= wdata;
    if (cmd.rd) begin
      rdata <= mem[idx];
      sq    <= wabs * wabs;
    end
  end

  // update arithmetic
  assign wabs     = wgt[31] ? 32'(-wgt) : wgt;
  assign is_fill  = (req == whb_pkg::REQ_FILL);
  assign is_count = (req == whb_pkg::REQ_COUNT);
  assign edge_bin = (idx == whb_pkg::IDX_UNDER) || (idx == whb_pkg::IDX_OVER);
  assign deep2    = track_depth[1];
  assign deep3    = (track_depth == 2'd3);
  assign old_sum  = rdata[143:96];
  assign old_sec  = rdata[95:32];
  assign old_hit  = rdata[31:0];
  assign addend   = is_count ? 49'sd65536 : 49'(wgt);
  assign sum_ext  = 49'(old_sum) + addend;
  assign sec_add  = {1'b0, old_sec} + {1'b0, sq};

  always_comb begin
    new_sum = old_sum;
    new_sec = old_sec;
    new_hit = old_hit;
    if (is_fill || is_count) begin
      if (sum_ext[48] != sum_ext[47])
        new_sum = sum_ext[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      else
        new_sum = sum_ext[47:0];
    end
    if (is_fill && deep2) begin
      if (edge_bin) begin
        if (!wgt[31] && {32'd0, wgt} > old_sec) new_sec = {32'd0, wgt};
      end else begin
        new_sec = sec_add[64] ? '1 : sec_add[63:0];
      end
      if (deep3 && old_hit != '1) new_hit = old_hit + 32'd1;
    end
  end

  assign wdata = {new_sum, new_sec, new_hit};

  // result register
  logic signed [47:0] res_sum;
  logic [63:0]        res_sec;
  logic [31:0]        res_hit;

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      res_sum <= new_sum;
      res_sec <= new_sec;
      res_hit <= new_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready)    out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      bin_placed    <= placed;
      bin_index     <= placed ? idx : '0;
      bin_sum       <= placed ? res_sum : '0;
      bin_second    <= placed ? res_sec : '0;
      bin_hits      <= placed ? res_hit : '0;
      total_fills   <= fill_counter;
      nonzero_fills <= nonzero_counter;
    end
  end

  assign st.route    = route;
  assign st.div_done = div_done;
  assign st.q_ok     = (quot < {23'd0, n_bins});
  assign st.clr_last = (clr_cnt == whb_pkg::IDX_LAST);
  assign st.out_busy = out_valid & ~out_ready;
endmodule
`default_nettype wire
